// ----- rtl/ocl_pkg.sv -----
package ocl_pkg;

  localparam logic [3:0] CODE_LEFT  = 4'b0001;
  localparam logic [3:0] CODE_RIGHT = 4'b0010;
  localparam logic [3:0] CODE_BELOW = 4'b0100;
  localparam logic [3:0] CODE_ABOVE = 4'b1000;

  localparam logic [2:0] MAX_MOVES = 3'd4;

  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  localparam int RST_LEFT   = 0;
  localparam int RST_BOTTOM = 0;
  localparam int RST_RIGHT  = 640;
  localparam int RST_TOP    = 480;

  // window registers are never narrower than the reset values need
  localparam int MIN_WIN_BITS = 12;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_phase_t;

endpackage

// ----- rtl/ocl_muldiv.sv -----
module ocl_muldiv import ocl_pkg::*; #(
  parameter int W = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [W-1:0] c,
  output logic                done,
  output logic signed [W-1:0] q
);

  localparam int CW = $clog2(W);

  md_phase_t      phase;
  logic [CW-1:0]  cnt;
  logic [2*W-1:0] p;
  logic [W-1:0]   mcand;
  logic [W-1:0]   divisor;
  logic           neg;
  logic           zdiv;

  logic [W-1:0] ma, mb, mc;
  logic [W:0]   sum;
  logic [W:0]   t;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_next;

  always_comb begin
    ma = a[W-1] ? W'(-a) : W'(a);
    mb = b[W-1] ? W'(-b) : W'(b);
    mc = c[W-1] ? W'(-c) : W'(c);
    // shift-add, one multiplier bit a cycle
    sum = {1'b0, p[2*W-1:W]} + (p[0] ? {1'b0, mcand} : '0);
    // restoring division, one quotient bit a cycle
    t = {p[2*W-1:W], p[W-1]};
    diff = t - {1'b0, divisor};
    ge = (t >= {1'b0, divisor});
    rem_next = ge ? diff[W-1:0] : t[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MD_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      unique case (phase)
        MD_IDLE: begin
          if (start) begin
            phase   <= MD_MUL;
            cnt     <= CW'(W - 1);
            p       <= {{W{1'b0}}, mb};
            mcand   <= ma;
            divisor <= mc;
            neg     <= a[W-1] ^ b[W-1] ^ c[W-1];
            zdiv    <= (mc == '0);
          end
        end
        MD_MUL: begin
          p <= {sum, p[W-1:1]};
          if (cnt == '0) begin
            phase <= MD_DIV;
            cnt   <= CW'(W - 1);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        MD_DIV: begin
          p <= {rem_next, p[W-2:0], ge};
          if (cnt == '0) begin
            phase <= MD_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: phase <= MD_IDLE;
      endcase
    end
  end

  always_comb begin
    priority if (zdiv) q = '0;
    else if (neg) q = -$signed(p[W-1:0]);
    else q = $signed(p[W-1:0]);
  end

endmodule

// ----- rtl/outcode_line_clipper_core.sv -----
// Cohen-Sutherland line clipper: each request carries one segment, and one result comes back
// for it with an accept flag and the clipped endpoints (all zero when rejected). The window
// is set through the register port and may only be changed while no segment is in flight.
// One segment is worked on at a time. A segment that needs no endpoint move goes from the
// check state straight to the finish state; each endpoint move passes through the calc and
// wait states while the shared multiply-divide unit works, which handles one bit a cycle
// over a shift-add multiply and a restoring divide. At most four moves are made. A segment
// holds the input until its result is loaded into the output register, and a full output
// register stalls that load. A finished result waits in the output register while the next
// segment is taken in.
module outcode_line_clipper_core import ocl_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // clipped_start_x, clipped_start_y, clipped_end_x, clipped_end_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0]     m_tdata,
  // accepted
  output logic                                  m_tuser,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [3:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int N        = COORD_BITS;
  localparam int W        = COORD_BITS + 1;
  localparam int TDW      = ((4*COORD_BITS+7)/8)*8;
  localparam int WIN_BITS = (COORD_BITS < MIN_WIN_BITS) ? MIN_WIN_BITS : COORD_BITS;

  logic signed [WIN_BITS-1:0] window_left, window_bottom, window_right, window_top;

  state_t              state;
  logic signed [N-1:0] x1, y1, x2, y2;
  logic [2:0]          moves;
  logic signed [W-1:0] opa, opb, opc;
  logic signed [N-1:0] ev;
  logic signed [N-1:0] base;
  logic                edge_y;
  logic                upd_first;

  logic                out_acc;
  logic signed [N-1:0] ox1, oy1, ox2, oy2;
  logic                acc_hold;
  logic                out_load;

  logic                md_start;
  logic                md_done;
  logic signed [W-1:0] md_q;

  logic                wr_en;
  logic signed [N-1:0] wr_val;

  logic [3:0]          c1, c2, co;
  logic signed [W-1:0] opa_next, opb_next, opc_next;
  logic signed [N-1:0] ev_next, base_next;
  logic                edge_y_next;
  logic signed [N-1:0] moved;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign wr_val = $signed(pwdata[N-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left   <= WIN_BITS'(RST_LEFT);
      window_bottom <= WIN_BITS'(RST_BOTTOM);
      window_right  <= WIN_BITS'(RST_RIGHT);
      window_top    <= WIN_BITS'(RST_TOP);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_LEFT:   window_left   <= WIN_BITS'(wr_val);
        REG_BOTTOM: window_bottom <= WIN_BITS'(wr_val);
        REG_RIGHT:  window_right  <= WIN_BITS'(wr_val);
        REG_TOP:    window_top    <= WIN_BITS'(wr_val);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LEFT:   prdata = 32'(window_left);
      REG_BOTTOM: prdata = 32'(window_bottom);
      REG_RIGHT:  prdata = 32'(window_right);
      REG_TOP:    prdata = 32'(window_top);
      default:    prdata = '0;
    endcase
  end

  // outcodes and edge selection
  always_comb begin
    c1 = '0;
    c2 = '0;
    if (WIN_BITS'(x1) < window_left)   c1 = c1 | CODE_LEFT;
    if (WIN_BITS'(x1) > window_right)  c1 = c1 | CODE_RIGHT;
    if (WIN_BITS'(y1) < window_bottom) c1 = c1 | CODE_BELOW;
    if (WIN_BITS'(y1) > window_top)    c1 = c1 | CODE_ABOVE;
    if (WIN_BITS'(x2) < window_left)   c2 = c2 | CODE_LEFT;
    if (WIN_BITS'(x2) > window_right)  c2 = c2 | CODE_RIGHT;
    if (WIN_BITS'(y2) < window_bottom) c2 = c2 | CODE_BELOW;
    if (WIN_BITS'(y2) > window_top)    c2 = c2 | CODE_ABOVE;
    co = (c1 != '0) ? c1 : c2;

    priority if ((co & CODE_ABOVE) != '0) begin
      edge_y_next = 1'b1;
      ev_next     = N'(window_top);
    end else if ((co & CODE_BELOW) != '0) begin
      edge_y_next = 1'b1;
      ev_next     = N'(window_bottom);
    end else if ((co & CODE_RIGHT) != '0) begin
      edge_y_next = 1'b0;
      ev_next     = N'(window_right);
    end else begin
      edge_y_next = 1'b0;
      ev_next     = N'(window_left);
    end

    if (edge_y_next) begin
      opa_next  = W'(x2) - W'(x1);
      opb_next  = W'(ev_next) - W'(y1);
      opc_next  = W'(y2) - W'(y1);
      base_next = x1;
    end else begin
      opa_next  = W'(y2) - W'(y1);
      opb_next  = W'(ev_next) - W'(x1);
      opc_next  = W'(x2) - W'(x1);
      base_next = y1;
    end
  end

  assign moved    = N'(W'(base) + md_q);
  assign md_start = (state == ST_CALC);

  ocl_muldiv #(.W(W)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (opa),
    .b     (opb),
    .c     (opc),
    .done  (md_done),
    .q     (md_q)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      moves    <= '0;
      acc_hold <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x1    <= $signed(s_tdata[N-1:0]);
            y1    <= $signed(s_tdata[2*N-1:N]);
            x2    <= $signed(s_tdata[3*N-1:2*N]);
            y2    <= $signed(s_tdata[4*N-1:3*N]);
            moves <= '0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          priority if (c1 == '0 && c2 == '0) begin
            acc_hold <= 1'b1;
            state    <= ST_FIN;
          end else if ((c1 & c2) != '0 || moves == MAX_MOVES) begin
            acc_hold <= 1'b0;
            state    <= ST_FIN;
          end else begin
            opa       <= opa_next;
            opb       <= opb_next;
            opc       <= opc_next;
            ev        <= ev_next;
            base      <= base_next;
            edge_y    <= edge_y_next;
            upd_first <= (c1 != '0);
            state     <= ST_CALC;
          end
        end
        ST_CALC: state <= ST_WAIT;
        ST_WAIT: begin
          if (md_done) begin
            priority if (upd_first && edge_y) begin
              x1 <= moved;
              y1 <= ev;
            end else if (upd_first) begin
              x1 <= ev;
              y1 <= moved;
            end else if (edge_y) begin
              x2 <= moved;
              y2 <= ev;
            end else begin
              x2 <= ev;
              y2 <= moved;
            end
            moves <= moves + 1'b1;
            state <= ST_CHECK;
          end
        end
        ST_FIN: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        out_acc  <= acc_hold;
        ox1      <= acc_hold ? x1 : '0;
        oy1      <= acc_hold ? y1 : '0;
        ox2      <= acc_hold ? x2 : '0;
        oy2      <= acc_hold ? y2 : '0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = TDW'({oy2, ox2, oy1, ox1});
  assign m_tuser = out_acc;

endmodule

// ----- rtl/ocl_checker.sv -----
module ocl_checker import ocl_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
  input logic                              m_tuser,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [3:0]                        paddr,
  input logic [31:0]                       pwdata,
  input logic                              pready
);

  localparam int N        = COORD_BITS;
  localparam int WIN_BITS = (COORD_BITS < MIN_WIN_BITS) ? MIN_WIN_BITS : COORD_BITS;

  logic signed [WIN_BITS-1:0] sh_left, sh_bottom, sh_right, sh_top;
  logic signed [WIN_BITS-1:0] rx1, ry1, rx2, ry2;
  logic                       in_window;

  // shadow copy of the window as seen on the register port
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_left   <= WIN_BITS'(RST_LEFT);
      sh_bottom <= WIN_BITS'(RST_BOTTOM);
      sh_right  <= WIN_BITS'(RST_RIGHT);
      sh_top    <= WIN_BITS'(RST_TOP);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_LEFT:   sh_left   <= WIN_BITS'($signed(pwdata[N-1:0]));
        REG_BOTTOM: sh_bottom <= WIN_BITS'($signed(pwdata[N-1:0]));
        REG_RIGHT:  sh_right  <= WIN_BITS'($signed(pwdata[N-1:0]));
        REG_TOP:    sh_top    <= WIN_BITS'($signed(pwdata[N-1:0]));
        default: ;
      endcase
    end
  end

  always_comb begin
    rx1 = WIN_BITS'($signed(m_tdata[N-1:0]));
    ry1 = WIN_BITS'($signed(m_tdata[2*N-1:N]));
    rx2 = WIN_BITS'($signed(m_tdata[3*N-1:2*N]));
    ry2 = WIN_BITS'($signed(m_tdata[4*N-1:3*N]));
    in_window = rx1 >= sh_left && rx1 <= sh_right && ry1 >= sh_bottom && ry1 <= sh_top &&
                rx2 >= sh_left && rx2 <= sh_right && ry2 >= sh_bottom && ry2 <= sh_top;
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("rejected segment with nonzero endpoints");

  a_accept_in_window: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> in_window)
    else $error("accepted endpoint outside the window");

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new request taken while a segment is being clipped");

endmodule

bind outcode_line_clipper_core ocl_checker #(.COORD_BITS(COORD_BITS)) u_ocl_checker (.*);
